FILE: design/message_deframer_crc32_check_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the message deframer
// Shared property forms with a common clock and asynchronous reset.
// ----------------------------------------------------------------------------
`ifndef MESSAGE_DEFRAMER_CRC32_CHECK_ASSERT_SVH
`define MESSAGE_DEFRAMER_CRC32_CHECK_ASSERT_SVH

// Same-cycle implication, disabled while reset is low
`define MDC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("deframer assertion failed");

// Next-cycle implication, disabled while reset is low
`define MDC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("deframer assertion failed");

`endif

FILE: design/mdc_pkg.sv
// ----------------------------------------------------------------------------
// Message deframer package
// Result kind codes, header constants and the byte-wise CRC-32 update.
// ----------------------------------------------------------------------------
package mdc_pkg;

    // Result kinds
    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_FRAME   = 2'd1;
    localparam logic [1:0] KIND_ERROR   = 2'd2;

    // Header versions
    localparam logic [1:0] VER_BASIC = 2'd0;
    localparam logic [1:0] VER_SEQ   = 2'd1;
    localparam logic [1:0] VER_FULL  = 2'd2;

    localparam logic [7:0] VER_MAX_BYTE = 8'd2;

    // Header sizes in bytes
    localparam logic [4:0] HDR_SIZE_BASIC = 5'd9;
    localparam logic [4:0] HDR_SIZE_SEQ   = 5'd17;
    localparam logic [4:0] HDR_SIZE_FULL  = 5'd29;

    // Shortest frame that passes the length check
    localparam logic [32:0] MIN_CHECK_LEN = 33'd29;

    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

    // Header size for a version
    function automatic logic [4:0] hdr_size(input logic [1:0] ver);
        logic [4:0] size;
        begin
            unique case (ver)
                VER_BASIC: size = HDR_SIZE_BASIC;
                VER_SEQ:   size = HDR_SIZE_SEQ;
                default:   size = HDR_SIZE_FULL;
            endcase
            return size;
        end
    endfunction

    // Reflected CRC-32 update by one byte
    function automatic logic [31:0] crc_feed(input logic [31:0] crc_in,
                                             input logic [7:0]  data);
        logic [31:0] crc;
        begin
            crc = crc_in ^ {24'd0, data};
            for (int k = 0; k < 8; k++) begin
                crc = (crc >> 1) ^ (crc[0] ? CRC_POLY : 32'd0);
            end
            return crc;
        end
    endfunction

endpackage

FILE: design/message_deframer_crc32_check.sv
// ----------------------------------------------------------------------------
// Length-prefixed message deframer with CRC-32 check
// Parses version, topic, length, sequence, timestamp and CRC header fields,
// passes payload bytes through and reports each frame with a check flag.
//
//   Channel  Handshake            Payload
//   input    in_valid / in_stall  data_byte
//   output   out_valid/out_stall  kind, payload_byte, header fields,
//                                 check_ok, last
//
// Each byte is parsed in the cycle it is accepted; its results enter a
// two-entry result queue and appear in the cycle after at the earliest.
// One byte per cycle is taken while the queue has room; a byte that ends a
// frame on a payload byte gives two results, and its entry holds both.
// in_stall rises only when both queue entries are occupied.
// Reset is asynchronous, active low, and starts parsing at a version byte.
// ----------------------------------------------------------------------------
`include "message_deframer_crc32_check_assert.svh"

module message_deframer_crc32_check
    import mdc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,

    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  kind,
    output logic [7:0]  payload_byte,
    output logic [1:0]  msg_version,
    output logic [31:0] topic_code,
    output logic [31:0] payload_length,
    output logic [63:0] seq_number,
    output logic [63:0] time_stamp,
    output logic [31:0] header_crc,
    output logic        check_ok,
    output logic        last
);

    // One queue entry: every result caused by one byte
    typedef struct packed {
        logic        is_err;
        logic        has_pay;
        logic        has_done;
        logic [7:0]  pay_byte;
        logic        ok;
        logic [1:0]  version;
        logic [31:0] topic;
        logic [31:0] length;
        logic [63:0] seq;
        logic [63:0] stamp;
        logic [31:0] hcrc;
    } res_entry_t;

    // Parser state
    logic [32:0] byte_idx_reg,   byte_idx_next;
    logic [32:0] frame_len_reg,  frame_len_next;
    logic [1:0]  version_reg,    version_next;
    logic [31:0] topic_reg,      topic_next;
    logic [31:0] length_reg,     length_next;
    logic [63:0] seq_reg,        seq_next;
    logic [63:0] stamp_reg,      stamp_next;
    logic [31:0] hdr_crc_reg,    hdr_crc_next;
    logic [31:0] crc_reg,        crc_next;
    logic [31:0] trailer_reg,    trailer_next;

    // Result queue
    res_entry_t  q_mem [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg,  count_next;
    logic        half_reg,   half_next;

    logic        in_acc;
    logic        out_acc;
    logic        push;
    logic        pop;
    res_entry_t  entry_new;
    res_entry_t  head;
    logic        two_res;

    logic        is_first;
    logic        idx_small;
    logic [4:0]  idx_lo;
    logic        bad_ver;
    logic        is_pay;
    logic        is_done;
    logic        ok_w;
    logic [4:0]  hs;
    logic [32:0] idx_inc;
    logic [1:0]  ver_w;
    logic [31:0] topic_w;
    logic [31:0] length_w;
    logic [63:0] seq_w;
    logic [63:0] stamp_w;
    logic [31:0] hcrc_w;
    logic [31:0] crc_w;
    logic [31:0] trailer_w;
    logic [32:0] flen_w;

    assign in_acc  = in_valid && !in_stall;
    assign out_acc = out_valid && !out_stall;

    // Parse the current byte against the header layout
    always_comb
    begin
        is_first  = (byte_idx_reg == 33'd0);
        idx_small = (byte_idx_reg[32:5] == 28'd0);
        idx_lo    = byte_idx_reg[4:0];
        bad_ver   = is_first && (data_byte > VER_MAX_BYTE);

        ver_w     = version_reg;
        topic_w   = topic_reg;
        length_w  = length_reg;
        seq_w     = seq_reg;
        stamp_w   = stamp_reg;
        hcrc_w    = hdr_crc_reg;
        crc_w     = crc_reg;
        trailer_w = trailer_reg;
        flen_w    = frame_len_reg;

        // Start a new frame on the version byte
        if (is_first) begin
            ver_w     = data_byte[1:0];
            topic_w   = 32'd0;
            length_w  = 32'd0;
            seq_w     = 64'd0;
            stamp_w   = 64'd0;
            hcrc_w    = 32'd0;
            crc_w     = ALL_ONES;
            trailer_w = 32'd0;
        end

        // Capture little-endian header fields
        for (int k = 0; k < 4; k++) begin
            if (idx_small && idx_lo == 5'(k + 1)) begin
                topic_w[8*k +: 8] = data_byte;
            end
            if (idx_small && idx_lo == 5'(k + 5)) begin
                length_w[8*k +: 8] = data_byte;
            end
            if (idx_small && idx_lo == 5'(k + 25) && ver_w == VER_FULL) begin
                hcrc_w[8*k +: 8] = data_byte;
            end
        end
        for (int k = 0; k < 8; k++) begin
            if (idx_small && idx_lo == 5'(k + 9) && ver_w != VER_BASIC) begin
                seq_w[8*k +: 8] = data_byte;
            end
            if (idx_small && idx_lo == 5'(k + 17) && ver_w == VER_FULL) begin
                stamp_w[8*k +: 8] = data_byte;
            end
        end

        // Fix the frame length once the length field is complete
        if (idx_small && idx_lo == 5'd8) begin
            flen_w = {28'd0, hdr_size(version_reg)} + {1'b0, length_w};
        end

        // Feed the byte leaving the four-byte trailer window into the CRC
        if (!idx_small || idx_lo >= 5'd4) begin
            crc_w = crc_feed(crc_w, trailer_w[7:0]);
        end
        trailer_w = {data_byte, trailer_w[31:8]};

        hs      = hdr_size(ver_w);
        idx_inc = byte_idx_reg + 33'd1;
        is_pay  = (byte_idx_reg >= {28'd0, hs});
        is_done = (byte_idx_reg >= 33'd8) && (idx_inc >= {28'd0, hs}) &&
                  (idx_inc == flen_w);

        if (ver_w == VER_FULL) begin
            ok_w = ((crc_w ^ ALL_ONES) == trailer_w);
        end
        else begin
            ok_w = (flen_w >= MIN_CHECK_LEN);
        end
    end

    // Advance parser state on an accepted byte
    always_comb
    begin
        byte_idx_next  = byte_idx_reg;
        frame_len_next = frame_len_reg;
        version_next   = version_reg;
        topic_next     = topic_reg;
        length_next    = length_reg;
        seq_next       = seq_reg;
        stamp_next     = stamp_reg;
        hdr_crc_next   = hdr_crc_reg;
        crc_next       = crc_reg;
        trailer_next   = trailer_reg;

        if (in_acc && !bad_ver) begin
            frame_len_next = flen_w;
            version_next   = ver_w;
            topic_next     = topic_w;
            length_next    = length_w;
            seq_next       = seq_w;
            stamp_next     = stamp_w;
            hdr_crc_next   = hcrc_w;
            if (is_done) begin
                byte_idx_next = 33'd0;
                crc_next      = ALL_ONES;
                trailer_next  = 32'd0;
            end
            else begin
                byte_idx_next = idx_inc;
                crc_next      = crc_w;
                trailer_next  = trailer_w;
            end
        end
    end

    // Build the queue entry for this byte
    always_comb
    begin
        entry_new.is_err   = bad_ver;
        entry_new.has_pay  = is_pay;
        entry_new.has_done = is_done;
        entry_new.pay_byte = data_byte;
        entry_new.ok       = ok_w;
        entry_new.version  = ver_w;
        entry_new.topic    = topic_w;
        entry_new.length   = length_w;
        entry_new.seq      = seq_w;
        entry_new.stamp    = stamp_w;
        entry_new.hcrc     = hcrc_w;
    end

    assign push = in_acc && (bad_ver || is_pay || is_done);

    // Queue control: one entry per byte that gives a result, popped after its last result
    always_comb
    begin
        head    = q_mem[rd_ptr_reg];
        two_res = head.has_pay && head.has_done && !head.is_err;
        pop     = out_acc && (!two_res || half_reg);

        half_next = half_reg;
        if (pop) begin
            half_next = 1'b0;
        end
        else if (out_acc) begin
            half_next = 1'b1;
        end

        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    assign in_stall  = (count_reg == 2'd2);
    assign out_valid = (count_reg != 2'd0);

    // Drive result fields from the head entry
    always_comb
    begin
        if (head.is_err) begin
            kind = KIND_ERROR;
        end
        else if (head.has_pay && !half_reg) begin
            kind = KIND_PAYLOAD;
        end
        else begin
            kind = KIND_FRAME;
        end

        last           = (kind != KIND_PAYLOAD) || !head.has_done;
        payload_byte   = (kind == KIND_PAYLOAD) ? head.pay_byte : 8'd0;
        msg_version    = (kind == KIND_FRAME)   ? head.version  : 2'd0;
        topic_code     = (kind == KIND_FRAME)   ? head.topic    : 32'd0;
        payload_length = (kind == KIND_FRAME)   ? head.length   : 32'd0;
        seq_number     = (kind == KIND_FRAME)   ? head.seq      : 64'd0;
        time_stamp     = (kind == KIND_FRAME)   ? head.stamp    : 64'd0;
        header_crc     = (kind == KIND_FRAME)   ? head.hcrc     : 32'd0;
        check_ok       = (kind == KIND_FRAME)   ? head.ok       : 1'b0;
    end

    // Hold queue entries
    always_ff @(posedge clk)
    begin
        if (push) begin
            q_mem[wr_ptr_reg] <= entry_new;
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            byte_idx_reg  <= 33'd0;
            frame_len_reg <= 33'd0;
            version_reg   <= VER_BASIC;
            topic_reg     <= 32'd0;
            length_reg    <= 32'd0;
            seq_reg       <= 64'd0;
            stamp_reg     <= 64'd0;
            hdr_crc_reg   <= 32'd0;
            crc_reg       <= ALL_ONES;
            trailer_reg   <= 32'd0;
            wr_ptr_reg    <= 1'b0;
            rd_ptr_reg    <= 1'b0;
            count_reg     <= 2'd0;
            half_reg      <= 1'b0;
        end
        else begin
            byte_idx_reg  <= byte_idx_next;
            frame_len_reg <= frame_len_next;
            version_reg   <= version_next;
            topic_reg     <= topic_next;
            length_reg    <= length_next;
            seq_reg       <= seq_next;
            stamp_reg     <= stamp_next;
            hdr_crc_reg   <= hdr_crc_next;
            crc_reg       <= crc_next;
            trailer_reg   <= trailer_next;
            wr_ptr_reg    <= wr_ptr_next;
            rd_ptr_reg    <= rd_ptr_next;
            count_reg     <= count_next;
            half_reg      <= half_next;
        end
    end

    // Past the length field, the frame end always lies ahead
    `MDC_ASSERT_SAME(a_len_ahead, clk, rst_n, byte_idx_reg > 33'd8, frame_len_reg > byte_idx_reg)
    // The second half of an entry exists only for a two-result entry
    `MDC_ASSERT_SAME(a_half_two, clk, rst_n, half_reg, (count_reg != 2'd0) && two_res)
    // A full queue with no pop stays full into the next cycle
    `MDC_ASSERT_NEXT(a_full_hold, clk, rst_n, (count_reg == 2'd2) && !pop, in_stall)

endmodule

FILE: tb/message_deframer_crc32_check_tb.sv
// ----------------------------------------------------------------------------
// Message deframer testbench
// Streams framed messages of all three header versions, unknown version
// bytes and frames with good and corrupted CRC trailers into the deframer.
// A scoreboard parses the same byte stream, queues the payload, frame and
// error results it should produce and checks every result the block hands
// out, field by field, under random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module message_deframer_crc32_check_tb
    import mdc_pkg::*;
();

    localparam int CYCLE_LIMIT = 400000;

    // One result of the deframer
    typedef struct {
        logic [1:0]  kind;
        logic [7:0]  payload_byte;
        logic [1:0]  msg_version;
        logic [31:0] topic_code;
        logic [31:0] payload_length;
        logic [63:0] seq_number;
        logic [63:0] time_stamp;
        logic [31:0] header_crc;
        logic        check_ok;
        logic        last;
    } deframe_result_t;

    // Parses the byte stream and holds the results still owed by the block
    class deframe_scoreboard;
        logic [63:0]     byte_pos;
        logic [63:0]     frame_len;
        logic [1:0]      ver;
        logic [31:0]     topic;
        logic [31:0]     plen;
        logic [63:0]     seq;
        logic [63:0]     stamp;
        logic [31:0]     hcrc;
        logic [31:0]     crc_acc;
        logic [31:0]     tail_bytes;
        deframe_result_t expected_q[$];
        int              errors;

        function new();
            byte_pos   = '0;
            frame_len  = '0;
            ver        = VER_BASIC;
            topic      = '0;
            plen       = '0;
            seq        = '0;
            stamp      = '0;
            hcrc       = '0;
            crc_acc    = ALL_ONES;
            tail_bytes = '0;
            errors     = 0;
        endfunction

        // Advance a reflected CRC-32 by one byte, LSB first
        function logic [31:0] crc_byte(logic [31:0] c, logic [7:0] d);
            logic [31:0] r;
            r = c;
            for (int j = 0; j < 8; j++) begin
                if (r[0] ^ d[j])
                    r = (r >> 1) ^ CRC_POLY;
                else
                    r = r >> 1;
            end
            return r;
        endfunction

        function logic [63:0] header_bytes(logic [1:0] v);
            if (v == VER_BASIC)
                return 64'(HDR_SIZE_BASIC);
            else if (v == VER_SEQ)
                return 64'(HDR_SIZE_SEQ);
            return 64'(HDR_SIZE_FULL);
        endfunction

        function deframe_result_t blank_result();
            deframe_result_t r;
            r.kind           = KIND_PAYLOAD;
            r.payload_byte   = '0;
            r.msg_version    = '0;
            r.topic_code     = '0;
            r.payload_length = '0;
            r.seq_number     = '0;
            r.time_stamp     = '0;
            r.header_crc     = '0;
            r.check_ok       = 1'b0;
            r.last           = 1'b0;
            return r;
        endfunction

        // Take one accepted item and queue the results it causes
        function void note_byte(logic [7:0] b);
            deframe_result_t r;
            int              k;
            logic [63:0]     hs;
            bit              is_payload;
            bit              is_done;

            k = int'(byte_pos);
            // version byte: drop unknown versions, else start a fresh header
            if (byte_pos == 0) begin
                if (b > VER_MAX_BYTE) begin
                    r = blank_result();
                    r.kind = KIND_ERROR;
                    r.last = 1'b1;
                    expected_q.push_back(r);
                    return;
                end
                ver        = b[1:0];
                topic      = '0;
                plen       = '0;
                seq        = '0;
                stamp      = '0;
                hcrc       = '0;
                crc_acc    = ALL_ONES;
                tail_bytes = '0;
            end else if (byte_pos <= 4) begin
                topic[8*(k-1) +: 8] = b;
            end else if (byte_pos <= 8) begin
                plen[8*(k-5) +: 8] = b;
                if (byte_pos == 8)
                    frame_len = header_bytes(ver) + 64'(plen);
            end else if (byte_pos <= 16) begin
                if (ver != VER_BASIC)
                    seq[8*(k-9) +: 8] = b;
            end else if (byte_pos <= 24) begin
                if (ver == VER_FULL)
                    stamp[8*(k-17) +: 8] = b;
            end else if (byte_pos <= 28) begin
                if (ver == VER_FULL)
                    hcrc[8*(k-25) +: 8] = b;
            end

            // CRC lags four bytes behind the stream
            if (byte_pos >= 4)
                crc_acc = crc_byte(crc_acc, tail_bytes[7:0]);
            tail_bytes = {b, tail_bytes[31:8]};

            hs         = header_bytes(ver);
            is_payload = (byte_pos >= hs);
            is_done    = (byte_pos >= 8) && (byte_pos + 1 >= hs) &&
                         (byte_pos + 1 == frame_len);

            if (is_payload) begin
                r = blank_result();
                r.kind         = KIND_PAYLOAD;
                r.payload_byte = b;
                r.last         = !is_done;
                expected_q.push_back(r);
            end
            if (is_done) begin
                r = blank_result();
                r.kind           = KIND_FRAME;
                r.msg_version    = ver;
                r.topic_code     = topic;
                r.payload_length = plen;
                r.seq_number     = seq;
                r.time_stamp     = stamp;
                r.header_crc     = hcrc;
                if (ver == VER_FULL)
                    r.check_ok = ((crc_acc ^ ALL_ONES) == tail_bytes);
                else
                    r.check_ok = (frame_len >= 64'(MIN_CHECK_LEN));
                r.last = 1'b1;
                expected_q.push_back(r);
                byte_pos   = '0;
                crc_acc    = ALL_ONES;
                tail_bytes = '0;
            end else begin
                byte_pos = byte_pos + 1;
            end
        endfunction

        function void compare_field(string name, logic [63:0] want, logic [63:0] seen);
            if (want !== seen) begin
                $error("%s: expected %0h, actual %0h", name, want, seen);
                errors++;
            end
        endfunction

        // Compare one delivered result with the oldest one owed
        function void check_result(deframe_result_t got);
            deframe_result_t want;
            if (expected_q.size() == 0) begin
                $error("result with none expected: kind %0d", got.kind);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            compare_field("kind",           want.kind,           got.kind);
            compare_field("payload_byte",   want.payload_byte,   got.payload_byte);
            compare_field("msg_version",    want.msg_version,    got.msg_version);
            compare_field("topic_code",     want.topic_code,     got.topic_code);
            compare_field("payload_length", want.payload_length, got.payload_length);
            compare_field("seq_number",     want.seq_number,     got.seq_number);
            compare_field("time_stamp",     want.time_stamp,     got.time_stamp);
            compare_field("header_crc",     want.header_crc,     got.header_crc);
            compare_field("check_ok",       want.check_ok,       got.check_ok);
            compare_field("last",           want.last,           got.last);
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  data_byte;
    logic        out_valid;
    logic        out_stall;
    logic [1:0]  kind;
    logic [7:0]  payload_byte;
    logic [1:0]  msg_version;
    logic [31:0] topic_code;
    logic [31:0] payload_length;
    logic [63:0] seq_number;
    logic [63:0] time_stamp;
    logic [31:0] header_crc;
    logic        check_ok;
    logic        last;

    deframe_scoreboard sb;
    int                send_idle_pct;
    int                stall_pct;
    int                bytes_sent;
    int                cycles;

    message_deframer_crc32_check dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .data_byte      (data_byte),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .kind           (kind),
        .payload_byte   (payload_byte),
        .msg_version    (msg_version),
        .topic_code     (topic_code),
        .payload_length (payload_length),
        .seq_number     (seq_number),
        .time_stamp     (time_stamp),
        .header_crc     (header_crc),
        .check_ok       (check_ok),
        .last           (last)
    );

    always #4 clk = ~clk;

    // Stop a hung run
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("message_deframer_crc32_check test failed");
            $finish;
        end
    end

    // Check each delivered result, then pick the next stall
    always @(posedge clk)
    begin : result_side
        deframe_result_t got;
        if (rst_n && out_valid && !out_stall) begin
            got.kind           = kind;
            got.payload_byte   = payload_byte;
            got.msg_version    = msg_version;
            got.topic_code     = topic_code;
            got.payload_length = payload_length;
            got.seq_number     = seq_number;
            got.time_stamp     = time_stamp;
            got.header_crc     = header_crc;
            got.check_ok       = check_ok;
            got.last           = last;
            sb.check_result(got);
        end
        out_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);
    end

    // Drive one item; returns at the edge that accepts it, valid left high
    task automatic send_byte(input logic [7:0] b);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_byte(b);
        bytes_sent++;
    endtask

    // Hold off the sender until every owed result has come back
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    function automatic logic [31:0] pick_word();
        case ($urandom_range(7))
            0:       return 32'hFFFF_FFFF;
            1:       return 32'h0;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] pick_length();
        int r;
        r = $urandom_range(19);
        if (r < 14)
            return $urandom_range(12);
        else if (r < 18)
            return $urandom_range(40, 13);
        return $urandom_range(90, 41);
    endfunction

    // Build one frame and stream it; payload is cut at max_payload bytes
    task automatic send_frame(input logic [1:0] ver, input logic [31:0] plen,
                              input logic [31:0] topic, input bit good_crc,
                              input int unsigned max_payload);
        logic [7:0]  fb[$];
        logic [63:0] seqv;
        logic [63:0] stampv;
        logic [31:0] hcrcv;
        logic [31:0] crc;
        int unsigned npay;
        int          n;

        seqv   = {pick_word(), pick_word()};
        stampv = {pick_word(), pick_word()};
        hcrcv  = pick_word();
        fb.push_back({6'd0, ver});
        for (int j = 0; j < 4; j++)
            fb.push_back(topic[8*j +: 8]);
        for (int j = 0; j < 4; j++)
            fb.push_back(plen[8*j +: 8]);
        if (ver != VER_BASIC) begin
            for (int j = 0; j < 8; j++)
                fb.push_back(seqv[8*j +: 8]);
        end
        if (ver == VER_FULL) begin
            for (int j = 0; j < 8; j++)
                fb.push_back(stampv[8*j +: 8]);
            for (int j = 0; j < 4; j++)
                fb.push_back(hcrcv[8*j +: 8]);
        end
        npay = (plen > max_payload) ? max_payload : plen;
        for (int unsigned j = 0; j < npay; j++)
            fb.push_back(8'($urandom));

        // seal a complete full-header frame with its CRC trailer
        if (ver == VER_FULL && npay == plen) begin
            n   = fb.size();
            crc = ALL_ONES;
            for (int j = 0; j < n - 4; j++)
                crc = sb.crc_byte(crc, fb[j]);
            crc = crc ^ ALL_ONES;
            if (!good_crc)
                crc = crc ^ (32'h1 << $urandom_range(31));
            for (int j = 0; j < 4; j++)
                fb[n-4+j] = crc[8*j +: 8];
        end

        foreach (fb[j])
            send_byte(fb[j]);
    endtask

    // Random frames with some unknown version bytes mixed in
    task automatic run_phase(input int tx_pct, input int rx_pct, input int budget);
        int       start;
        logic [1:0] v;
        send_idle_pct = tx_pct;
        stall_pct     = rx_pct;
        start         = bytes_sent;
        while (bytes_sent - start < budget) begin
            if ($urandom_range(99) < 8) begin
                send_byte(8'($urandom_range(255, 3)));
            end else begin
                v = 2'($urandom_range(2));
                send_frame(v, pick_length(), pick_word(),
                           (v != VER_FULL) || ($urandom_range(3) != 0), 1000);
            end
        end
        drain();
    endtask

    initial
    begin
        clk           = 1'b0;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        data_byte     = 8'h00;
        out_stall     = 1'b0;
        send_idle_pct = 0;
        stall_pct     = 0;
        bytes_sent    = 0;
        cycles        = 0;
        sb            = new();

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: unknown versions, empty payload, length check boundary,
        // good and bad CRC trailers
        send_byte(8'hFF);
        send_byte(8'h03);
        send_frame(VER_BASIC, 32'd0,  32'hFFFF_FFFF, 1'b1, 1000);
        send_frame(VER_BASIC, 32'd20, 32'h0,         1'b1, 1000);
        send_frame(VER_SEQ,   32'd11, 32'h8000_0001, 1'b1, 1000);
        send_frame(VER_FULL,  32'd0,  32'h1234_5678, 1'b1, 1000);
        send_frame(VER_FULL,  32'd5,  32'hA5A5_5A5A, 1'b0, 1000);
        send_frame(VER_FULL,  32'd6,  32'hFFFF_FFFF, 1'b1, 1000);
        drain();

        run_phase(0,  0,  70);
        run_phase(48, 0,  70);
        run_phase(0,  48, 70);
        run_phase(35, 35, 70);

        // top length: frame never ends, payload keeps flowing
        send_frame(VER_SEQ, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 40);

        drain();
        repeat (10) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("message_deframer_crc32_check test passed");
        else
            $display("message_deframer_crc32_check test failed");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+design
design/mdc_pkg.sv
design/message_deframer_crc32_check.sv
tb/message_deframer_crc32_check_tb.sv
